### rtl/core/mfe_pkg.sv
`default_nettype none
package mfe_pkg;

  // Defaults for the top level parameters
  localparam int LENGTH_BITS_DEF  = 24;
  localparam int MARKER_BYTES_DEF = 8;

  // Boundary marker after reset: "--RaNd0m", first byte most significant
  localparam logic [63:0] MARKER_RESET = 64'h2D2D_5261_4E64_306D;

  // Character constants
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Length of the "Content-length: " prefix
  localparam logic [4:0] CL_LEN = 5'd16;

  // Parser phases
  typedef enum logic [2:0] {
    PH_BOUNDARY = 3'd0,
    PH_CLEN     = 3'd1,
    PH_LENGTH   = 3'd2,
    PH_BLANK    = 3'd3,
    PH_PAYLOAD  = 3'd4
  } phase_t;

  // Result error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_DIGITS   = 3'd1,
    ERR_ZERO     = 3'd2,
    ERR_BLANK    = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    err_t       error_code;
  } result_t;

  // Character k of "Content-length: "
  function automatic logic [7:0] cl_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/multipart_frame_extractor_top.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_stream_byte[7:0]
// out_      output     out_valid / out_stall out_payload_byte[7:0], out_frame_end,
//                                           out_error_code[2:0]
// cfg_      input      cfg_wr_en            cfg_wr_data[63:0] (boundary marker)
//
// One stream byte per cycle while in_stall is low: the parser state and a one-byte
// compare or a times-ten add decide each byte, and any result is registered in
// the output register, or in the skid stage while that register is held.
// A two-entry output buffer (output register plus skid stage) lets input run
// on while one result waits; in_stall rises only when both entries are full.
// Reset (rst_n low, synchronous) clears the parser and the output buffer and
// loads the default marker.
module multipart_frame_extractor_top import mfe_pkg::*; #(
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF,
  parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_payload_byte,
  output logic             out_frame_end,
  output logic [2:0]       out_error_code,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // Accept a transaction whenever the output buffer has room
  assign accept = in_valid && !in_stall;

  mfe_parser #(
    .LENGTH_BITS  (LENGTH_BITS),
    .MARKER_BYTES (MARKER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .stream_byte (in_stream_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  mfe_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack the result transaction
  assign out_payload_byte = out_data.payload_byte;
  assign out_frame_end    = out_data.frame_end;
  assign out_error_code   = out_data.error_code;

endmodule
`default_nettype wire

### rtl/core/mfe_parser.sv
`default_nettype none
module mfe_parser import mfe_pkg::*; #(
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF,
  parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  stream_byte,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  output logic             res_valid,
  output result_t          res
);

  localparam int          PW     = LENGTH_BITS + 4;
  localparam logic [4:0]  MB_LEN = 5'(MARKER_BYTES);

  phase_t                   phase_r, phase_nxt;
  logic [4:0]               pos_r, pos_nxt;
  logic                     mis_r, mis_nxt;
  logic [LENGTH_BITS-1:0]   acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [7:0]               held_r, held_nxt;
  logic                     held_v_r, held_v_nxt;
  logic [LENGTH_BITS-1:0]   rem_r, rem_nxt;
  logic [63:0]              marker_r;

  logic [4:0]               cur_len;
  logic [7:0]               want;
  logic [3:0]               digit;
  logic                     is_digit;
  logic [PW-1:0]            prod;
  logic [LENGTH_BITS-1:0]   rem_dec;
  err_t                     len_err;

  // Match target for the current line
  always_comb begin
    cur_len = (phase_r == PH_BOUNDARY) ? MB_LEN : CL_LEN;
    want    = (phase_r == PH_BOUNDARY) ? marker_r[8*(7-pos_r[2:0]) +: 8]
                                       : cl_char(pos_r[3:0]);
  end

  // Decimal step on the held-back character: acc * 10 + digit
  always_comb begin
    digit    = 4'(held_r - CHAR_ZERO);
    is_digit = (held_r >= CHAR_ZERO) && (held_r <= CHAR_NINE);
    prod     = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + PW'(digit);
    rem_dec  = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
  end

  // Length line verdict at its newline
  always_comb begin
    if (mis_r || pos_r == 5'd0) begin
      len_err = ERR_DIGITS;
    end else if (ovf_r) begin
      len_err = ERR_OVERFLOW;
    end else if (acc_r == '0) begin
      len_err = ERR_ZERO;
    end else begin
      len_err = ERR_NONE;
    end
  end

  // Next state and result for one accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    mis_nxt    = mis_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    rem_nxt    = rem_r;
    res_valid  = 1'b0;
    res        = '{payload_byte: 8'd0, frame_end: 1'b0, error_code: ERR_NONE};
    if (accept) begin
      case (phase_r)
        PH_BOUNDARY, PH_CLEN: begin
          if (stream_byte == CHAR_LF) begin
            pos_nxt = 5'd0;
            mis_nxt = 1'b0;
          end else if (!mis_r && pos_r < cur_len) begin
            if (stream_byte != want) begin
              mis_nxt = 1'b1;
            end else if (pos_r == cur_len - 5'd1) begin
              pos_nxt = 5'd0;
              if (phase_r == PH_BOUNDARY) begin
                // skip the rest of the boundary line
                phase_nxt = PH_CLEN;
                mis_nxt   = 1'b1;
              end else begin
                phase_nxt  = PH_LENGTH;
                mis_nxt    = 1'b0;
                acc_nxt    = '0;
                ovf_nxt    = 1'b0;
                held_v_nxt = 1'b0;
                held_nxt   = 8'd0;
              end
            end else begin
              pos_nxt = pos_r + 5'd1;
            end
          end
        end
        PH_LENGTH: begin
          if (stream_byte != CHAR_LF) begin
            // digest the previous character, hold back this one
            if (held_v_r) begin
              if (is_digit) begin
                pos_nxt = 5'd1;
                if (!ovf_r) begin
                  if (prod[PW-1:LENGTH_BITS] != 4'd0) begin
                    ovf_nxt = 1'b1;
                  end else begin
                    acc_nxt = prod[LENGTH_BITS-1:0];
                  end
                end
              end else begin
                mis_nxt = 1'b1;
              end
            end
            held_nxt   = stream_byte;
            held_v_nxt = 1'b1;
          end else begin
            held_v_nxt = 1'b0;
            pos_nxt    = 5'd0;
            mis_nxt    = 1'b0;
            if (len_err != ERR_NONE) begin
              phase_nxt      = PH_BOUNDARY;
              res_valid      = 1'b1;
              res.error_code = len_err;
            end else begin
              phase_nxt = PH_BLANK;
            end
          end
        end
        PH_BLANK: begin
          if (stream_byte != CHAR_LF) begin
            if (pos_r != 5'd0 || stream_byte != CHAR_CR) begin
              mis_nxt = 1'b1;
            end
            if (pos_r < 5'd31) begin
              pos_nxt = pos_r + 5'd1;
            end
          end else begin
            pos_nxt = 5'd0;
            mis_nxt = 1'b0;
            if (pos_r == 5'd1 && !mis_r) begin
              rem_nxt   = acc_r;
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt      = PH_BOUNDARY;
              res_valid      = 1'b1;
              res.error_code = ERR_BLANK;
            end
          end
        end
        PH_PAYLOAD: begin
          // pass the byte through, mark the last one
          rem_nxt          = rem_dec;
          res_valid        = 1'b1;
          res.payload_byte = stream_byte;
          if (rem_dec == '0) begin
            res.frame_end = 1'b1;
            phase_nxt     = PH_BOUNDARY;
            pos_nxt       = 5'd0;
            mis_nxt       = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_BOUNDARY;
          pos_nxt   = 5'd0;
          mis_nxt   = 1'b0;
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BOUNDARY;
      pos_r    <= 5'd0;
      mis_r    <= 1'b0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      held_r   <= 8'd0;
      held_v_r <= 1'b0;
      rem_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      mis_r    <= mis_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      rem_r    <= rem_nxt;
    end
  end

  // Boundary marker register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_wr_en) begin
      marker_r <= cfg_wr_data;
    end
  end

endmodule
`default_nettype wire

### rtl/core/mfe_out_skid.sv
`default_nettype none
module mfe_out_skid import mfe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire result_t  push_data,
  output logic          full,
  output logic          out_valid,
  input  wire logic     out_stall,
  output result_t       out_data
);

  logic    main_v_r;
  result_t main_r;
  logic    skid_v_r;
  result_t skid_r;
  logic    pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // Valid flags of the output register and the skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (!main_v_r) begin
      main_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload: advance skid into the output register, or park a new result
  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_r <= skid_r;
    end else if (push && (pop || !main_v_r)) begin
      main_r <= push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import mfe_pkg::*;

  localparam int          LEN_BITS    = LENGTH_BITS_DEF;
  localparam int          MARK_BYTES  = MARKER_BYTES_DEF;
  localparam logic [39:0] LEN_CEILING = (40'd1 << LEN_BITS) - 40'd1;
  localparam logic [127:0] CLEN_TEXT  = "Content-length: ";
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned DRAIN_WAIT  = 8;
  // Boundary marker with a newline byte in it: can never match
  localparam logic [63:0] MARKER_WITH_LF = 64'h2D2D_0A61_6231_3233;

  // Tracks the parser and the frame bytes and error reports it must produce
  class deframe_tracker;
    logic [63:0]         marker;
    phase_t              phase;
    logic [4:0]          match_pos;
    logic                mismatch;
    logic [LEN_BITS-1:0] len_acc;
    logic                overflow;
    logic [7:0]          held_char;
    logic                held_valid;
    logic [LEN_BITS-1:0] remaining;
    result_t             pending_results[$];
    int unsigned         mismatches;

    function new();
      marker     = MARKER_RESET;
      start_line(PH_BOUNDARY);
      len_acc    = '0;
      overflow   = 1'b0;
      held_char  = 8'h00;
      held_valid = 1'b0;
      remaining  = '0;
      mismatches = 0;
    endfunction

    function void set_marker(logic [63:0] value);
      marker = value;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void start_line(phase_t next);
      phase     = next;
      match_pos = 5'd0;
      mismatch  = 1'b0;
    endfunction

    function void expect_result(logic [7:0] data, logic last, err_t code);
      result_t r;
      r.payload_byte = data;
      r.frame_end    = last;
      r.error_code   = code;
      pending_results.push_back(r);
    endfunction

    // Fold one length character into the accumulator
    function void fold_digit(logic [7:0] c);
      logic [39:0] grown;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        match_pos = 5'd1;
        if (!overflow) begin
          grown = 40'(len_acc) * 40'd10 + 40'(c - CHAR_ZERO);
          if (grown > LEN_CEILING) overflow = 1'b1;
          else len_acc = grown[LEN_BITS-1:0];
        end
      end else begin
        mismatch = 1'b1;
      end
    endfunction

    // Advance the parser by one accepted stream byte
    function void take_byte(logic [7:0] c);
      logic [7:0] want;
      int unsigned span;
      err_t code;
      case (phase)
        PH_BOUNDARY, PH_CLEN: begin
          span = (phase == PH_BOUNDARY) ? MARK_BYTES : int'(CL_LEN);
          if (c == CHAR_LF) begin
            start_line(phase);
          end else if (!mismatch && match_pos < span) begin
            want = (phase == PH_BOUNDARY) ? marker[63 - 8*match_pos -: 8]
                                          : CLEN_TEXT[127 - 8*match_pos -: 8];
            if (c != want) begin
              mismatch = 1'b1;
            end else begin
              match_pos++;
              if (match_pos == span) begin
                if (phase == PH_BOUNDARY) begin
                  // skip the rest of the boundary line
                  phase     = PH_CLEN;
                  match_pos = 5'd0;
                  mismatch  = 1'b1;
                end else begin
                  phase      = PH_LENGTH;
                  match_pos  = 5'd0;
                  mismatch   = 1'b0;
                  len_acc    = '0;
                  overflow   = 1'b0;
                  held_valid = 1'b0;
                  held_char  = 8'h00;
                end
              end
            end
          end
        end
        PH_LENGTH: begin
          if (c != CHAR_LF) begin
            // hold back one character: the last one of the line is dropped
            if (held_valid) fold_digit(held_char);
            held_char  = c;
            held_valid = 1'b1;
          end else begin
            held_valid = 1'b0;
            if (mismatch || match_pos == 5'd0) code = ERR_DIGITS;
            else if (overflow)                 code = ERR_OVERFLOW;
            else if (len_acc == '0)            code = ERR_ZERO;
            else                               code = ERR_NONE;
            if (code != ERR_NONE) begin
              start_line(PH_BOUNDARY);
              expect_result(8'h00, 1'b0, code);
            end else begin
              start_line(PH_BLANK);
            end
          end
        end
        PH_BLANK: begin
          if (c != CHAR_LF) begin
            if (match_pos != 5'd0 || c != CHAR_CR) mismatch = 1'b1;
            if (match_pos < 5'd31) match_pos++;
          end else if (match_pos == 5'd1 && !mismatch) begin
            remaining = len_acc;
            start_line(PH_PAYLOAD);
          end else begin
            start_line(PH_BOUNDARY);
            expect_result(8'h00, 1'b0, ERR_BLANK);
          end
        end
        PH_PAYLOAD: begin
          if (remaining != '0) remaining--;
          if (remaining == '0) begin
            start_line(PH_BOUNDARY);
            expect_result(c, 1'b1, ERR_NONE);
          end else begin
            expect_result(c, 1'b0, ERR_NONE);
          end
        end
        default: start_line(PH_BOUNDARY);
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [7:0] data, logic last, logic [2:0] code);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result payload_byte=%h frame_end=%b error_code=%0d",
                 $time, data, last, code);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (data !== exp_r.payload_byte) begin
        $display("%0t: payload_byte expected %h actual %h", $time, exp_r.payload_byte, data);
        mismatches++;
      end
      if (last !== exp_r.frame_end) begin
        $display("%0t: frame_end expected %b actual %b", $time, exp_r.frame_end, last);
        mismatches++;
      end
      if (code !== exp_r.error_code) begin
        $display("%0t: error_code expected %0d actual %0d", $time, exp_r.error_code, code);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_payload_byte;
  logic        out_frame_end;
  logic [2:0]  out_error_code;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  deframe_tracker deframer;
  logic [63:0]    marker_now;
  int unsigned    cycle_count = 0;
  int unsigned    bytes_sent  = 0;
  bit             hold_request = 1'b0;

  multipart_frame_extractor_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_stream_byte  (in_stream_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_frame_end   (out_frame_end),
    .out_error_code  (out_error_code),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multipart_frame_extractor_top regression: fail");
      $finish;
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      deframer.check_result(out_payload_byte, out_frame_end, out_error_code);
  end

  // Receiver: random stalls, calm stretches and one long hold on request
  initial begin
    int unsigned span;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (cycle_count[9:8] != 2'b01 && $urandom_range(0, 4) == 0) begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (span) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int unsigned pick_gap();
    if (cycle_count[8:7] == 2'b00) return 0;
    case ($urandom_range(0, 19))
      0:          return $urandom_range(8, 25);
      1, 2, 3, 4: return $urandom_range(1, 3);
      default:    return 0;
    endcase
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == CHAR_LF) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] any_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [63:0] random_marker();
    logic [63:0] m;
    m = {$urandom, $urandom};
    for (int k = 0; k < 8; k++)
      if (m[63 - 8*k -: 8] == CHAR_LF) m[63 - 8*k -: 8] = 8'h41;
    return m;
  endfunction

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframer.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CHAR_LF);
  endtask

  task automatic send_marker_bytes();
    for (int k = 0; k < MARK_BYTES; k++) send_byte(marker_now[63 - 8*k -: 8]);
  endtask

  task automatic send_boundary_line(input int unsigned rest);
    send_marker_bytes();
    repeat (rest) send_byte(any_but_lf());
    send_byte(CHAR_LF);
  endtask

  task automatic send_length_line(input string digits, input logic [7:0] tail);
    send_text("Content-length: ");
    send_text(digits);
    send_byte(tail);
    send_byte(CHAR_LF);
  endtask

  task automatic send_blank();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_frame(input int unsigned n, input bit extra_line);
    send_boundary_line($urandom_range(0, 6));
    if (extra_line) begin
      send_text("Server: cam");
      send_blank();
    end
    send_length_line($sformatf("%0d", n), CHAR_CR);
    send_blank();
    send_payload(n);
  endtask

  // Length line with one non-digit among the digits
  task automatic send_bad_length();
    logic [7:0] odd;
    int unsigned lead;
    int unsigned trail;
    lead  = $urandom_range(0, 3);
    trail = $urandom_range(0, 3);
    odd   = any_but_lf();
    while (odd >= CHAR_ZERO && odd <= CHAR_NINE) odd = any_but_lf();
    send_text("Content-length: ");
    repeat (lead) send_byte(any_digit());
    send_byte(odd);
    repeat (trail) send_byte(any_digit());
    send_blank();
  endtask

  task automatic send_bad_blank();
    case ($urandom_range(0, 3))
      0: send_byte(CHAR_LF);
      1: begin
        send_byte(CHAR_CR);
        send_blank();
      end
      2: begin
        send_byte(any_but_lf());
        send_blank();
      end
      default: begin
        send_byte(CHAR_CR);
        send_byte(any_but_lf());
        send_byte(CHAR_LF);
      end
    endcase
  endtask

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
  endfunction

  // Mostly well-formed frames, the rest broken headers and noise
  task automatic run_random(input int unsigned budget);
    int unsigned first;
    int unsigned pick;
    int unsigned spot;
    logic [63:0] saved;
    string       zero_digits;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(pick_len(), $urandom_range(0, 3) == 0);
      end else if (pick < 63) begin
        send_boundary_line($urandom_range(0, 3));
        send_bad_length();
      end else if (pick < 67) begin
        if ($urandom_range(0, 1) != 0) zero_digits = "0";
        else zero_digits = "000";
        send_boundary_line(0);
        send_length_line(zero_digits, CHAR_CR);
      end else if (pick < 71) begin
        send_boundary_line(0);
        send_length_line($sformatf("%0d%0d", $urandom_range(2, 9),
                                   $urandom_range(10000000, 99999999)), CHAR_CR);
      end else if (pick < 79) begin
        send_boundary_line($urandom_range(0, 3));
        send_length_line($sformatf("%0d", pick_len()), CHAR_CR);
        send_bad_blank();
      end else if (pick < 89) begin
        repeat ($urandom_range(0, 20)) send_byte(8'($urandom));
        send_byte(CHAR_LF);
      end else if (pick < 95) begin
        // marker line with one byte spoiled, then a length line
        saved = marker_now;
        spot  = $urandom_range(0, 7);
        marker_now[63 - 8*spot -: 8] = marker_now[63 - 8*spot -: 8]
                                       ^ 8'($urandom_range(1, 255));
        send_boundary_line(0);
        marker_now = saved;
        send_length_line("4", CHAR_CR);
      end else begin
        send_boundary_line(1);
        send_text("Content-lengtX: 5");
        send_blank();
      end
    end
  endtask

  // Drain every result before touching the marker register
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (deframer.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_marker(input logic [63:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    deframer.set_marker(value);
    marker_now = value;
  endtask

  initial begin
    deframer       = new();
    marker_now     = MARKER_RESET;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_stream_byte = 8'h00;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 64'h0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: frame sizes, header quirks and every error report
    send_frame(1, 1'b0);
    send_frame(3, 1'b1);
    send_marker_bytes();
    send_text(" Content-length: 5");
    send_blank();
    send_length_line("2", CHAR_CR);
    send_blank();
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_boundary_line(0);
    send_length_line("12a", CHAR_CR);
    send_boundary_line(0);
    send_length_line("-5", CHAR_CR);
    send_boundary_line(0);
    send_length_line("", CHAR_CR);
    send_boundary_line(0);
    send_line("Content-length: ");
    send_boundary_line(0);
    send_length_line("000", CHAR_CR);
    send_boundary_line(0);
    send_length_line("16777216", CHAR_CR);
    send_boundary_line(0);
    send_length_line("1x999999999", CHAR_CR);
    send_boundary_line(0);
    send_length_line("16777215", CHAR_CR);
    send_byte(CHAR_LF);
    send_boundary_line(0);
    send_length_line("5", CHAR_CR);
    send_byte(CHAR_CR);
    send_blank();
    // last character of the length line is dropped whatever it is
    send_boundary_line(0);
    send_length_line("3", "7");
    send_blank();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_LF);
    send_boundary_line(2);
    send_length_line("0005", CHAR_CR);
    send_blank();
    send_payload(5);
    send_line("Content-length: 9");
    // long frame with the receiver held off so the block backs up
    send_boundary_line(0);
    send_length_line("24", CHAR_CR);
    send_blank();
    hold_request = 1'b1;
    send_payload(24);

    run_random(30);
    write_marker(64'h0);
    run_random(5);
    write_marker(64'hFFFF_FFFF_FFFF_FFFF);
    run_random(5);
    write_marker(MARKER_WITH_LF);
    run_random(5);
    write_marker(random_marker());
    run_random(5);
    write_marker(MARKER_RESET);
    run_random(5);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (deframer.mismatches == 0 && deframer.pending() == 0)
      $display("multipart_frame_extractor_top regression: pass");
    else
      $display("multipart_frame_extractor_top regression: fail");
    $finish;
  end

endmodule
